@@ sv/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check on the rising clock edge, off while in reset
`define DPM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication check
`define DPM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

@@ sv/dpm_pkg.sv @@
package dpm_pkg;

  localparam int unsigned DefPaletteDepth = 16;
  localparam int unsigned ChanW    = 8;
  localparam int unsigned ColorW   = 24;
  localparam int unsigned IdxW     = 4;
  localparam int unsigned DsqW     = 18;
  localparam int unsigned DistW    = 10;
  localparam int unsigned RootW    = 20;
  localparam int unsigned SizeW    = 5;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 5;
  localparam int unsigned QuoW     = 16;
  localparam int unsigned TW       = 17;

  localparam logic [SizeW-1:0] SizeReset = 5'd16;
  localparam logic [DistW-1:0] DistNone  = '1;
  localparam logic [DsqW-1:0]  DsqMax    = 18'd195075;
  localparam logic signed [TW-1:0] THalf = 17'sd128;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PALETTE_SIZE = 1'b0,
    CFG_DITHER_ON    = 1'b1
  } cfg_reg_e;

  // 4x4 ordered dither thresholds, indexed by {row, column}
  localparam logic [3:0] Bayer [16] = '{
    4'd0,  4'd8,  4'd2,  4'd10,
    4'd12, 4'd4,  4'd14, 4'd6,
    4'd3,  4'd11, 4'd1,  4'd9,
    4'd15, 4'd7,  4'd13, 4'd5
  };

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic [1:0]       column_phase;
    logic [1:0]       row_phase;
  } side_t;

  typedef struct packed {
    logic [DistW-1:0]  rdist;
    logic [DsqW-1:0]   dsq;
    logic [IdxW-1:0]   idx;
    logic [ColorW-1:0] color;
  } cand_t;

  typedef struct packed {
    cand_t first;
    cand_t second;
  } pair_t;

  typedef struct packed {
    logic [DsqW-1:0]  rem;
    logic [RootW-1:0] root;
  } sqrt_t;

  function automatic logic [ChanW-1:0] abs_diff(input logic [ChanW-1:0] a,
                                                input logic [ChanW-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  // one digit of the bitwise integer square root
  function automatic sqrt_t isqrt_step(input sqrt_t s, input logic [RootW-1:0] bitv);
    logic [RootW-1:0] trial;
    sqrt_t r;
    trial = s.root + bitv;
    if ({2'b00, s.rem} >= trial) begin
      r.rem  = s.rem - trial[DsqW-1:0];
      r.root = (s.root >> 1) + bitv;
    end else begin
      r.rem  = s.rem;
      r.root = s.root >> 1;
    end
    return r;
  endfunction

  // one restoring division step: {quotient bit, new remainder}
  function automatic logic [ChanW:0] div_step(input logic [ChanW-1:0] rem,
                                              input logic [ChanW-1:0] den,
                                              input logic nb);
    logic [ChanW:0] r9;
    r9 = {rem, nb};
    if (r9 >= {1'b0, den}) begin
      return {1'b1, ChanW'(r9 - {1'b0, den})};
    end
    return {1'b0, r9[ChanW-1:0]};
  endfunction

  // hi has the larger index and wins ties
  function automatic pair_t rank_leaf(input cand_t lo, input cand_t hi);
    pair_t p;
    if (hi.rdist <= lo.rdist) begin
      p.first  = hi;
      p.second = lo;
    end else begin
      p.first  = lo;
      p.second = hi;
    end
    return p;
  endfunction

  function automatic pair_t rank_merge(input pair_t a, input pair_t b);
    pair_t p;
    if (b.first.rdist <= a.first.rdist) begin
      p.first  = b.first;
      p.second = (b.second.rdist <= a.first.rdist) ? b.second : a.first;
    end else begin
      p.first  = a.first;
      p.second = (b.first.rdist <= a.second.rdist) ? b.first : a.second;
    end
    return p;
  endfunction

endpackage

@@ sv/dpm_if.sv @@
interface dpm_in_if;
  import dpm_pkg::*;
  logic             valid;
  logic             ready;
  logic             mode;
  logic [IdxW-1:0]  entry_index;
  logic [ChanW-1:0] red;
  logic [ChanW-1:0] green;
  logic [ChanW-1:0] blue;
  logic [1:0]       column_phase;
  logic [1:0]       row_phase;

  modport source (output valid, mode, entry_index, red, green, blue, column_phase, row_phase,
                  input ready);
  modport sink (input valid, mode, entry_index, red, green, blue, column_phase, row_phase,
                output ready);
endinterface

interface dpm_out_if;
  import dpm_pkg::*;
  logic             valid;
  logic             ready;
  logic [IdxW-1:0]  palette_index;
  logic [ChanW-1:0] out_red;
  logic [ChanW-1:0] out_green;
  logic [ChanW-1:0] out_blue;
  logic [DsqW-1:0]  pixel_error;

  modport source (output valid, palette_index, out_red, out_green, out_blue, pixel_error,
                  input ready);
  modport sink (input valid, palette_index, out_red, out_green, out_blue, pixel_error,
                output ready);
endinterface

@@ sv/dpm_rank_tree.sv @@
`include "assert_macros.svh"

module dpm_rank_tree #(
  parameter int unsigned Leaves = dpm_pkg::DefPaletteDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           vld_i,
  input  dpm_pkg::side_t side_i,
  input  dpm_pkg::cand_t leaves_i [Leaves],
  output logic           vld_o,
  output dpm_pkg::side_t side_o,
  output dpm_pkg::pair_t best_o
);
  import dpm_pkg::*;

  localparam int unsigned Levels = $clog2(Leaves);
  localparam int unsigned Nodes  = Leaves - 1;

  // nodes of level l sit from Leaves - (Leaves >> l)
  pair_t             node_q [Nodes];
  pair_t             node_d [Nodes];
  logic [Levels-1:0] vld_q;
  side_t             side_q [Levels];

  always_comb begin
    for (int n = 0; n < Leaves / 2; n++) begin
      node_d[n] = rank_leaf(leaves_i[2*n], leaves_i[2*n+1]);
    end
    for (int l = 1; l < Levels; l++) begin
      for (int n = 0; n < (Leaves >> (l + 1)); n++) begin
        node_d[Leaves - (Leaves >> l) + n] =
          rank_merge(node_q[Leaves - (Leaves >> (l - 1)) + 2*n],
                     node_q[Leaves - (Leaves >> (l - 1)) + 2*n + 1]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= Levels'({vld_q, vld_i});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      node_q    <= node_d;
      side_q[0] <= side_i;
      for (int l = 1; l < Levels; l++) begin
        side_q[l] <= side_q[l-1];
      end
    end
  end

  assign vld_o  = vld_q[Levels-1];
  assign side_o = side_q[Levels-1];
  assign best_o = node_q[Nodes-1];

  `DPM_ASSERT_IMPL(a_rank_order, clk_i, rst_ni, vld_o, best_o.first.rdist <= best_o.second.rdist, "second entry nearer than first")

endmodule

@@ sv/dpm_blend_div.sv @@
`include "assert_macros.svh"

module dpm_blend_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           vld_i,
  input  dpm_pkg::side_t                 side_i,
  input  dpm_pkg::pair_t                 pair_i,
  output logic                           vld_o,
  output dpm_pkg::side_t                 side_o,
  output dpm_pkg::pair_t                 pair_o,
  output logic signed [dpm_pkg::TW-1:0]  t_o [3]
);
  import dpm_pkg::*;

  localparam int unsigned Steps  = 4;
  localparam int unsigned PerStp = QuoW / Steps;
  localparam int unsigned Stages = Steps + 2;

  typedef struct packed {
    logic [ChanW-1:0] ax;
    logic [ChanW-1:0] ay;
    logic [ChanW-1:0] rem;
    logic [QuoW-1:0]  quo;
    logic             neg;
    logic             eq;
  } chan_t;

  chan_t             ch_q [Steps+1][3];
  chan_t             ch_d [Steps+1][3];
  logic signed [TW-1:0] t_q [3];
  logic signed [TW-1:0] t_d [3];
  logic [Stages-1:0] vld_q;
  side_t             side_q [Stages];
  pair_t             pair_q [Stages];

  always_comb begin
    logic [ColorW-1:0] pix;
    logic [ChanW-1:0]  p, a, b;
    logic [ChanW:0]    st;
    int                pos;
    pix = {side_i.red, side_i.green, side_i.blue};
    // prep: magnitudes and signs of (p - c1) and (c2 - c1)
    for (int c = 0; c < 3; c++) begin
      p = pix[ColorW-1-ChanW*c -: ChanW];
      a = pair_i.first.color[ColorW-1-ChanW*c -: ChanW];
      b = pair_i.second.color[ColorW-1-ChanW*c -: ChanW];
      ch_d[0][c].ax  = abs_diff(p, a);
      ch_d[0][c].ay  = abs_diff(b, a);
      ch_d[0][c].neg = (p < a) ^ (b < a);
      ch_d[0][c].eq  = (a == b);
      ch_d[0][c].rem = '0;
      ch_d[0][c].quo = '0;
    end
    // restoring divide of ax*256 by ay, a few quotient bits per stage
    for (int s = 1; s <= Steps; s++) begin
      for (int c = 0; c < 3; c++) begin
        ch_d[s][c] = ch_q[s-1][c];
        for (int j = 0; j < PerStp; j++) begin
          pos = QuoW - 1 - PerStp*(s-1) - j;
          st  = div_step(ch_d[s][c].rem, ch_d[s][c].ay,
                         (pos >= ChanW) ? ch_d[s][c].ax[pos-ChanW] : 1'b0);
          ch_d[s][c].rem      = st[ChanW-1:0];
          ch_d[s][c].quo[pos] = st[ChanW];
        end
      end
    end
    for (int c = 0; c < 3; c++) begin
      if (ch_q[Steps][c].eq) begin
        t_d[c] = THalf;
      end else if (ch_q[Steps][c].neg) begin
        t_d[c] = -$signed({1'b0, ch_q[Steps][c].quo});
      end else begin
        t_d[c] = $signed({1'b0, ch_q[Steps][c].quo});
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Stages-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ch_q      <= ch_d;
      t_q       <= t_d;
      side_q[0] <= side_i;
      pair_q[0] <= pair_i;
      for (int k = 1; k < Stages; k++) begin
        side_q[k] <= side_q[k-1];
        pair_q[k] <= pair_q[k-1];
      end
    end
  end

  assign vld_o  = vld_q[Stages-1];
  assign side_o = side_q[Stages-1];
  assign pair_o = pair_q[Stages-1];
  assign t_o    = t_q;

  `DPM_ASSERT_IMPL(a_div_rem, clk_i, rst_ni, vld_q[Steps] && !ch_q[Steps][0].eq, ch_q[Steps][0].rem < ch_q[Steps][0].ay, "division remainder not below divisor")

endmodule

@@ sv/dithered_palette_pixel_mapper_top.sv @@
// throughput: one word per cycle on both sides; the whole pipe holds while the output stalls
// load words write the palette on accept and give no result
// reset: valid bits clear, palette_size returns to 16 and dither_on to 1
// palette entries hold no reset value and must be written before use
`include "assert_macros.svh"

module dithered_palette_pixel_mapper_top #(
  parameter int unsigned PaletteDepth = dpm_pkg::DefPaletteDepth
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [dpm_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [dpm_pkg::CfgDataW-1:0]   cfg_data_i,
  dpm_in_if.sink                         in_ch,
  dpm_out_if.source                      out_ch
);
  import dpm_pkg::*;

  localparam int unsigned Leaves = 2 ** $clog2(PaletteDepth);
  localparam int unsigned CmpW   = 9;   // holds any lane number up to 256

  // per-lane pipeline payload
  typedef struct packed {
    logic [2*ChanW-1:0] sq_r;
    logic [2*ChanW-1:0] sq_g;
    logic [2*ChanW-1:0] sq_b;
    logic [ColorW-1:0]  color;
    logic               active;
  } lane_sq_t;

  typedef struct packed {
    sqrt_t             s;
    logic [DsqW-1:0]   dsq;
    logic [ColorW-1:0] color;
    logic              active;
  } lane_rt_t;

  // configuration
  logic [SizeW-1:0] size_q;
  logic             dither_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q   <= SizeReset;
      dither_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_PALETTE_SIZE: size_q   <= cfg_data_i[SizeW-1:0];
        CFG_DITHER_ON:    dither_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // handshake: everything advances together unless the result word is held
  logic pipe_en, acc, pix_acc, load_we;
  logic out_vld_q;

  assign pipe_en      = !out_vld_q || out_ch.ready;
  assign in_ch.ready  = pipe_en;
  assign acc          = in_ch.valid && pipe_en;
  assign pix_acc      = acc && in_ch.mode;
  assign load_we      = acc && !in_ch.mode;

  // palette store, one register per entry; slots beyond the depth never match
  logic [ColorW-1:0] pal_q [PaletteDepth];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < PaletteDepth; i++) begin
      if (load_we && ({5'd0, in_ch.entry_index} == CmpW'(i))) begin
        pal_q[i] <= {in_ch.red, in_ch.green, in_ch.blue};
      end
    end
  end

  // front pipe: squares, sum, then the square root three digits a stage
  //   stage 0: per-channel squares
  //   stage 1: squared distance
  //   stages 2..4: root digits 8..6, 5..3, 2..0
  logic [4:0] vld_q;
  side_t      side_q [5];
  lane_sq_t   a_q [PaletteDepth];
  lane_sq_t   a_d [PaletteDepth];
  lane_rt_t   rt_q [4][PaletteDepth];
  lane_rt_t   rt_d [4][PaletteDepth];
  cand_t      leaf [Leaves];

  always_comb begin
    logic [ChanW-1:0] dr, dg, db;
    sqrt_t            s;
    for (int i = 0; i < PaletteDepth; i++) begin
      dr = abs_diff(in_ch.red,   pal_q[i][ColorW-1 -: ChanW]);
      dg = abs_diff(in_ch.green, pal_q[i][2*ChanW-1 -: ChanW]);
      db = abs_diff(in_ch.blue,  pal_q[i][ChanW-1:0]);
      a_d[i].sq_r   = {8'd0, dr} * {8'd0, dr};
      a_d[i].sq_g   = {8'd0, dg} * {8'd0, dg};
      a_d[i].sq_b   = {8'd0, db} * {8'd0, db};
      a_d[i].color  = pal_q[i];
      // entries in use saturate to 2..depth
      a_d[i].active = (i < 2) || ({4'd0, size_q} > CmpW'(i));
    end
    for (int i = 0; i < PaletteDepth; i++) begin
      rt_d[0][i].dsq    = DsqW'(a_q[i].sq_r) + DsqW'(a_q[i].sq_g) + DsqW'(a_q[i].sq_b);
      rt_d[0][i].s.rem  = rt_d[0][i].dsq;
      rt_d[0][i].s.root = '0;
      rt_d[0][i].color  = a_q[i].color;
      rt_d[0][i].active = a_q[i].active;
    end
    for (int st = 1; st < 4; st++) begin
      for (int i = 0; i < PaletteDepth; i++) begin
        s = rt_q[st-1][i].s;
        for (int j = 0; j < 3; j++) begin
          s = isqrt_step(s, RootW'(1) << (2 * (8 - 3*(st-1) - j)));
        end
        rt_d[st][i]   = rt_q[st-1][i];
        rt_d[st][i].s = s;
      end
    end
  end

  // tree leaves; lanes out of use or past the depth never rank
  always_comb begin
    for (int i = 0; i < Leaves; i++) begin
      if (i < PaletteDepth) begin
        leaf[i].rdist = rt_q[3][i].active ? rt_q[3][i].s.root[DistW-1:0] : DistNone;
        leaf[i].dsq   = rt_q[3][i].dsq;
        leaf[i].idx   = IdxW'(i);
        leaf[i].color = rt_q[3][i].color;
      end else begin
        leaf[i] = '{rdist: DistNone, default: '0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (pipe_en) begin
      vld_q <= {vld_q[3:0], pix_acc};
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      side_q[0] <= '{red: in_ch.red, green: in_ch.green, blue: in_ch.blue,
                     column_phase: in_ch.column_phase, row_phase: in_ch.row_phase};
      for (int k = 1; k < 5; k++) begin
        side_q[k] <= side_q[k-1];
      end
      a_q  <= a_d;
      rt_q <= rt_d;
    end
  end

  // nearest and second nearest, one tree level per stage
  logic  vld_t;
  side_t side_t_w;
  pair_t pair_t_w;

  dpm_rank_tree #(
    .Leaves (Leaves)
  ) u_rank (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (pipe_en),
    .vld_i    (vld_q[4]),
    .side_i   (side_q[4]),
    .leaves_i (leaf),
    .vld_o    (vld_t),
    .side_o   (side_t_w),
    .best_o   (pair_t_w)
  );

  // blend factors per channel, fixed point with 8 fraction bits
  logic                 vld_v;
  side_t                side_v;
  pair_t                pair_v;
  logic signed [TW-1:0] t_v [3];

  dpm_blend_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (pipe_en),
    .vld_i  (vld_t),
    .side_i (side_t_w),
    .pair_i (pair_t_w),
    .vld_o  (vld_v),
    .side_o (side_v),
    .pair_o (pair_v),
    .t_o    (t_v)
  );

  // threshold compare: keep nearest when 256*threshold >= 5*(Tr+Tg+Tb)
  logic signed [TW+1:0] tsum;
  logic signed [21:0]   rhs, lhs;
  logic                 keep;
  cand_t                pick;

  always_comb begin
    tsum = (TW+2)'(t_v[0]) + (TW+2)'(t_v[1]) + (TW+2)'(t_v[2]);
    rhs  = (22'(tsum) <<< 2) + 22'(tsum);
    lhs  = $signed({10'd0, Bayer[{side_v.row_phase, side_v.column_phase}], 8'd0});
    keep = (lhs >= rhs);
    pick = (dither_q && !keep) ? pair_v.second : pair_v.first;
  end

  // output register
  logic [IdxW-1:0]   idx_q;
  logic [ColorW-1:0] color_q;
  logic [DsqW-1:0]   err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (pipe_en) begin
      out_vld_q <= vld_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      idx_q   <= pick.idx;
      color_q <= pick.color;
      err_q   <= pick.dsq;
    end
  end

  assign out_ch.valid         = out_vld_q;
  assign out_ch.palette_index = idx_q;
  assign out_ch.out_red       = color_q[ColorW-1 -: ChanW];
  assign out_ch.out_green     = color_q[2*ChanW-1 -: ChanW];
  assign out_ch.out_blue      = color_q[ChanW-1:0];
  assign out_ch.pixel_error   = err_q;

  `DPM_ASSERT_IMPL(a_err_range, clk_i, rst_ni, out_vld_q, err_q <= DsqMax, "pixel error out of range")
  `DPM_ASSERT(a_hold_front, clk_i, rst_ni, !pipe_en |=> $stable(vld_q), "front pipe moved during stall")

endmodule

@@ dv/dithered_palette_pixel_mapper_top_tb.sv @@
`timescale 1ns / 1ps

module dithered_palette_pixel_mapper_top_tb;
  import dpm_pkg::*;

  localparam int unsigned Depth      = 16;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned SettleCyc  = 24;

  // one word on the input channel
  typedef struct {
    logic             mode;
    logic [IdxW-1:0]  slot;
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic [1:0]       col;
    logic [1:0]       row;
  } pix_word_t;

  // one mapped pixel on the output channel
  typedef struct {
    logic [IdxW-1:0]  index;
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic [DsqW-1:0]  err;
  } mapped_t;

  class palette_scoreboard;
    logic [ColorW-1:0] palette [Depth];
    logic [SizeW-1:0]  size_reg;
    logic              dither_reg;
    mapped_t           pending_q [$];
    int                errors;

    function new();
      size_reg   = SizeReset;
      dither_reg = 1'b1;
      errors     = 0;
      foreach (palette[i]) palette[i] = '0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [CfgDataW-1:0] val);
      if (idx == CFG_PALETTE_SIZE) size_reg = val[SizeW-1:0];
      else dither_reg = val[0];
    endfunction

    function automatic int unsigned root_floor(int unsigned v);
      int unsigned root;
      int unsigned b;
      root = 0;
      b = 1 << 30;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= root + b) begin
          v = v - (root + b);
          root = (root >> 1) + b;
        end else begin
          root = root >> 1;
        end
        b = b >> 2;
      end
      return root;
    endfunction

    function automatic int unsigned color_dsq(pix_word_t w, logic [ColorW-1:0] c);
      int dr, dg, db;
      dr = int'(w.red) - int'(c[23:16]);
      dg = int'(w.green) - int'(c[15:8]);
      db = int'(w.blue) - int'(c[7:0]);
      return dr * dr + dg * dg + db * db;
    endfunction

    // fixed point blend factor, 8 fraction bits, truncated toward zero
    function automatic int blend(int p, int a, int b);
      if (a == b) return 128;
      return ((p - a) * 256) / (b - a);
    endfunction

    function void note_word(pix_word_t w);
      int unsigned n, d, d1, d2, i1, i2, pick;
      int tsum;
      logic [ColorW-1:0] c1, c2, c;
      mapped_t m;
      if (w.mode == 1'b0) begin
        palette[w.slot] = {w.red, w.green, w.blue};
        return;
      end
      n = size_reg;
      if (n < 2) n = 2;
      if (n > Depth) n = Depth;
      d1 = '1; d2 = '1; i1 = 0; i2 = 0;
      for (int unsigned i = 0; i < n; i++) begin
        d = root_floor(color_dsq(w, palette[i]));
        if (d <= d1) begin
          d2 = d1; i2 = i1; d1 = d; i1 = i;
        end else if (d <= d2) begin
          d2 = d; i2 = i;
        end
      end
      pick = i1;
      if (dither_reg) begin
        c1 = palette[i1];
        c2 = palette[i2];
        tsum = blend(w.red, c1[23:16], c2[23:16]) + blend(w.green, c1[15:8], c2[15:8])
             + blend(w.blue, c1[7:0], c2[7:0]);
        if (!(int'(Bayer[{w.row, w.col}]) * 256 >= 5 * tsum)) pick = i2;
      end
      c = palette[pick];
      m.index = pick[IdxW-1:0];
      m.red   = c[23:16];
      m.green = c[15:8];
      m.blue  = c[7:0];
      m.err   = DsqW'(color_dsq(w, c));
      pending_q.insert(pending_q.size(), m);
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
    endtask

    task check_result(mapped_t got);
      mapped_t exp;
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word index %0d", got.index));
        return;
      end
      exp = pending_q.pop_front();
      if (got.index !== exp.index || got.red !== exp.red || got.green !== exp.green ||
          got.blue !== exp.blue || got.err !== exp.err)
        report_mismatch($sformatf("got %0d %h%h%h e%0d exp %0d %h%h%h e%0d",
          got.index, got.red, got.green, got.blue, got.err,
          exp.index, exp.red, exp.green, exp.blue, exp.err));
    endtask

    function int waiting();
      return pending_q.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  dpm_in_if  in_ch ();
  dpm_out_if out_ch ();

  dithered_palette_pixel_mapper_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  palette_scoreboard sb = new();

  // idle odds in percent, changed per phase
  int          send_idle_pct;
  int          recv_stall_pct;
  // long receiver hold-off, counted down by the receiver process
  int          hold_left;
  int unsigned cycles;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver: check what the block hands over, then pick ready for the next edge
  always @(posedge clk_i) begin
    mapped_t got;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got.index = out_ch.palette_index;
      got.red   = out_ch.out_red;
      got.green = out_ch.out_green;
      got.blue  = out_ch.out_blue;
      got.err   = out_ch.pixel_error;
      sb.check_result(got);
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // register write; only called with the pipe empty
  task write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk_i);
  endtask

  // offer one word, with random idle cycles ahead of it; valid stays high afterward
  task put_word(pix_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.mode         <= w.mode;
    in_ch.entry_index  <= w.slot;
    in_ch.red          <= w.red;
    in_ch.green        <= w.green;
    in_ch.blue         <= w.blue;
    in_ch.column_phase <= w.col;
    in_ch.row_phase    <= w.row;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sb.note_word(w);
  endtask

  // wait for every expected word, then let the pipe settle
  task drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.waiting() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  function automatic pix_word_t mk(logic mode, int slot, int r, int g, int b, int c, int rw);
    pix_word_t w;
    w.mode = mode;
    w.slot = IdxW'(slot);
    w.red = ChanW'(r); w.green = ChanW'(g); w.blue = ChanW'(b);
    w.col = 2'(c); w.row = 2'(rw);
    return w;
  endfunction

  function automatic int jitter(int v);
    v = v + $urandom_range(40) - 20;
    return (v < 0) ? 0 : ((v > 255) ? 255 : v);
  endfunction

  // random word: mostly pixels, many close to a palette color so the dither has work
  function automatic pix_word_t rand_word();
    pix_word_t w;
    logic [ColorW-1:0] c;
    w = mk(1'b1, $urandom_range(15), $urandom_range(255), $urandom_range(255),
           $urandom_range(255), $urandom_range(3), $urandom_range(3));
    case ($urandom_range(9))
      0, 1: w.mode = 1'b0;
      2, 3, 4, 5: begin
        c = sb.palette[$urandom_range(Depth - 1)];
        w.red   = ChanW'(jitter(c[23:16]));
        w.green = ChanW'(jitter(c[15:8]));
        w.blue  = ChanW'(jitter(c[7:0]));
      end
      default: ;
    endcase
    return w;
  endfunction

  initial begin
    logic [CfgDataW-1:0] sizes [8];
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_PALETTE_SIZE;
    cfg_data_i     = '0;
    in_ch.valid    = 1'b0;
    in_ch.mode     = 1'b0;
    in_ch.entry_index  = '0;
    in_ch.red      = '0;
    in_ch.green    = '0;
    in_ch.blue     = '0;
    in_ch.column_phase = '0;
    in_ch.row_phase    = '0;
    out_ch.ready   = 1'b1;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 0;
    cycles         = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill every slot first so no unwritten entry is ever read
    for (int i = 0; i < Depth; i++)
      put_word(mk(1'b0, i, (i * 17) & 8'hff, 255 - i * 16, (i * 73) & 8'hff, 0, 0));
    put_word(mk(1'b0, 0, 0, 0, 0, 0, 0));
    put_word(mk(1'b0, 15, 255, 255, 255, 0, 0));
    // slots 1 and 2 share green so that channel blends at one half
    put_word(mk(1'b0, 1, 40, 100, 200, 0, 0));
    put_word(mk(1'b0, 2, 60, 100, 10, 0, 0));
    // pixel extremes and every corner of the threshold grid
    put_word(mk(1'b1, 0, 0, 0, 0, 0, 0));
    put_word(mk(1'b1, 0, 255, 255, 255, 3, 3));
    put_word(mk(1'b1, 0, 50, 100, 105, 0, 3));
    put_word(mk(1'b1, 0, 50, 100, 105, 2, 1));
    put_word(mk(1'b1, 0, 255, 0, 255, 3, 0));
    put_word(mk(1'b1, 0, 128, 128, 128, 1, 2));
    drain();

    // dither off, and a data word whose low bit alone decides
    write_reg(CFG_DITHER_ON, 5'b10110);
    put_word(mk(1'b1, 0, 50, 100, 105, 0, 3));
    put_word(mk(1'b1, 0, 0, 255, 0, 1, 1));
    drain();
    write_reg(CFG_DITHER_ON, 5'd1);

    sizes = '{5'd2, 5'd16, 5'd0, 5'd31, 5'd1, 5'd17, 5'd9, 5'd5};
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_PALETTE_SIZE, sizes[ph]);
      write_reg(CFG_DITHER_ON, CfgDataW'($urandom_range(31)));
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      // long hold-off while words keep coming, so the pipe fills and input stalls
      if (ph == 4) hold_left = 300;
      for (int k = 0; k < 50; k++) put_word(rand_word());
      drain();
    end

    if (sb.waiting() != 0) sb.report_mismatch("results never arrived");
    if (sb.errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
